### rtl/core/ptm_pkg.sv
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants for the two-level page table manager: table
// pool sizing, address field widths, operation codes, control states and the
// memory request bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package ptm_pkg;

    // table pool and directory geometry
    localparam int NUM_TABLES  = 64;
    localparam int DIR_DEPTH   = 1024;
    localparam int TAB_ENTRIES = 1024;
    localparam int IDX_W       = 10;
    localparam int TN_W        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam int CNT_W       = $clog2(NUM_TABLES + 1);
    localparam int DENT_W      = TN_W + 1;
    localparam int TAB_AW      = TN_W + IDX_W;
    localparam int TAB_DEPTH   = NUM_TABLES * TAB_ENTRIES;

    // field widths
    localparam int ADDR_W = 32;
    localparam int FLAG_W = 12;
    localparam int OFF_W  = 12;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_MAP    = 2'd0,
        FUNC_UNMAP  = 2'd1,
        FUNC_LOOKUP = 2'd2
    } func_t;

    // control states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_FILL,
        ST_TAB
    } state_t;

    // requests to the directory and table memories
    typedef struct packed {
        logic              dir_rd;
        logic              dir_wr;
        logic [IDX_W-1:0]  dir_addr;
        logic [DENT_W-1:0] dir_wdata;
        logic              tab_rd;
        logic              tab_wr;
        logic [TAB_AW-1:0] tab_addr;
        logic [ADDR_W-1:0] tab_wdata;
    } mem_req_t;

endpackage

`default_nettype wire

### rtl/core/ptm_mem.sv
// ----------------------------------------------------------------------------
// ptm_mem
// Directory and page table storage: two single-port synchronous memories
// with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptm_mem (
    input  wire logic                                clk,
    input  wire ptm_pkg::mem_req_t                   req,
    output logic [ptm_pkg::DENT_W-1:0]               dir_q,
    output logic [ptm_pkg::ADDR_W-1:0]               tab_q
);
    import ptm_pkg::*;

    logic [DENT_W-1:0] dir_mem [DIR_DEPTH];
    logic [ADDR_W-1:0] tab_mem [TAB_DEPTH];

    // directory port
    always_ff @(posedge clk)
    begin
        if (req.dir_wr)
        begin
            dir_mem[req.dir_addr] <= req.dir_wdata;
        end
        if (req.dir_rd)
        begin
            dir_q <= dir_mem[req.dir_addr];
        end
    end

    // page table port
    always_ff @(posedge clk)
    begin
        if (req.tab_wr)
        begin
            tab_mem[req.tab_addr] <= req.tab_wdata;
        end
        if (req.tab_rd)
        begin
            tab_q <= tab_mem[req.tab_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/two_level_page_table_manager.sv
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// One page directory over a pool of page tables, with map, unmap and
// lookup operations on a stream interface.
// ----------------------------------------------------------------------------
// After reset the block clears all 1024 entries of the page directory, one
// entry per cycle, with s_tready low. It then works on one operation at a
// time: a lookup whose directory entry is present goes through transfer,
// directory read and table read; every other operation that allocates no
// table goes through transfer and directory read with any table write. A map
// that allocates a new table sweeps all 1024 entries of that table through
// the single table memory port, one per cycle. While the output register is
// occupied, an operation holds its last step until the previous result has
// been taken. A finished result waits in the output register while the next
// operation is taken in.
`default_nettype none

module two_level_page_table_manager (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // virt_addr[31:0], phys_addr[63:32], map_flags[75:64], zero fill
    input  wire logic [79:0] s_tdata,
    // func[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // phys_out[31:0], entry_flags[43:32], present[44], tlb_invalidate[45],
    // status[46], zero fill
    output logic [47:0]      m_tdata
);
    import ptm_pkg::*;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    next_free_reg, next_free_next;
    logic [TN_W-1:0]     tn_reg, tn_next;
    func_t               func_reg;
    logic [ADDR_W-1:0]   va_reg;
    logic [ADDR_W-1:0]   pa_reg;
    logic [FLAG_W-1:0]   flags_reg;

    logic                m_tvalid_reg;
    logic [ADDR_W-1:0]   phys_out_reg;
    logic [FLAG_W-1:0]   entry_flags_reg;
    logic                present_reg;
    logic                inval_reg;
    logic                status_reg;

    mem_req_t            req;
    logic [DENT_W-1:0]   dir_q;
    logic [ADDR_W-1:0]   tab_q;

    logic                res_load;
    logic [ADDR_W-1:0]   res_phys;
    logic [FLAG_W-1:0]   res_flags;
    logic                res_present;
    logic                res_inval;
    logic                res_status;

    logic                slot_free;
    logic                accept;
    logic                dir_present;
    logic [TN_W-1:0]     dent_tn;
    logic [IDX_W-1:0]    di;
    logic [IDX_W-1:0]    ti;
    logic [ADDR_W-1:0]   map_word;
    logic                pool_full;

    ptm_mem u_mem (
        .clk   (clk),
        .req   (req),
        .dir_q (dir_q),
        .tab_q (tab_q)
    );

    // decode of the captured operation and the directory entry
    assign slot_free   = !m_tvalid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign dir_present = dir_q[0];
    assign dent_tn     = dir_q[DENT_W-1:1];
    assign di          = va_reg[31:22];
    assign ti          = va_reg[21:12];
    assign map_word    = {pa_reg[ADDR_W-1:OFF_W], flags_reg};
    assign pool_full   = (next_free_reg == CNT_W'(NUM_TABLES));

    // state register and operation counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            next_free_reg <= '0;
            tn_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            next_free_reg <= next_free_next;
            tn_reg        <= tn_next;
        end
    end

    // captured operation fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func_t'(s_tuser);
            va_reg    <= s_tdata[31:0];
            pa_reg    <= s_tdata[63:32];
            flags_reg <= s_tdata[75:64];
        end
    end

    // next state, memory requests and result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        next_free_next = next_free_reg;
        tn_next        = tn_reg;
        req            = '0;
        s_tready       = 1'b0;
        res_load       = 1'b0;
        res_phys       = '0;
        res_flags      = '0;
        res_present    = 1'b0;
        res_inval      = 1'b0;
        res_status     = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // directory clearing pass after reset
                req.dir_wr    = 1'b1;
                req.dir_addr  = idx_reg;
                req.dir_wdata = '0;
                idx_next      = idx_reg + 1'b1;
                if (&idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    req.dir_rd   = 1'b1;
                    req.dir_addr = s_tdata[31:22];
                    state_next   = ST_DIR;
                end
            end

            ST_DIR:
            begin
                case (func_reg)
                    FUNC_MAP:
                    begin
                        if (dir_present)
                        begin
                            if (slot_free)
                            begin
                                req.tab_wr    = 1'b1;
                                req.tab_addr  = {dent_tn, ti};
                                req.tab_wdata = map_word;
                                res_inval     = 1'b1;
                                res_load      = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        else if (pool_full)
                        begin
                            if (slot_free)
                            begin
                                res_status = 1'b1;
                                res_load   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            // allocate the next table and start its sweep
                            req.dir_wr     = 1'b1;
                            req.dir_addr   = di;
                            req.dir_wdata  = {next_free_reg[TN_W-1:0], 1'b1};
                            tn_next        = next_free_reg[TN_W-1:0];
                            next_free_next = next_free_reg + 1'b1;
                            idx_next       = '0;
                            state_next     = ST_FILL;
                        end
                    end

                    FUNC_UNMAP:
                    begin
                        if (slot_free)
                        begin
                            if (dir_present)
                            begin
                                req.tab_wr    = 1'b1;
                                req.tab_addr  = {dent_tn, ti};
                                req.tab_wdata = '0;
                                res_inval     = 1'b1;
                            end
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end

                    FUNC_LOOKUP:
                    begin
                        if (dir_present)
                        begin
                            req.tab_rd   = 1'b1;
                            req.tab_addr = {dent_tn, ti};
                            state_next   = ST_TAB;
                        end
                        else if (slot_free)
                        begin
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end

                    default:
                    begin
                        if (slot_free)
                        begin
                            res_load   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_FILL:
            begin
                // sweep of the new table, the mapped entry gets the map word
                req.tab_addr  = {tn_reg, idx_reg};
                req.tab_wdata = (idx_reg == ti) ? map_word : '0;
                if (&idx_reg)
                begin
                    if (slot_free)
                    begin
                        req.tab_wr = 1'b1;
                        res_inval  = 1'b1;
                        res_load   = 1'b1;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    req.tab_wr = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                end
            end

            ST_TAB:
            begin
                if (slot_free)
                begin
                    res_flags = tab_q[FLAG_W-1:0];
                    if (tab_q[0])
                    begin
                        res_present = 1'b1;
                        res_phys    = {tab_q[ADDR_W-1:OFF_W], va_reg[OFF_W-1:0]};
                    end
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            phys_out_reg    <= res_phys;
            entry_flags_reg <= res_flags;
            present_reg     <= res_present;
            inval_reg       <= res_inval;
            status_reg      <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, status_reg, inval_reg, present_reg,
                       entry_flags_reg, phys_out_reg};

endmodule

`default_nettype wire
